// ===== rtl/hca_pkg.sv =====
// ----------------------------------------------------------------------------
// HSL color adjust package
// Shared widths, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package hca_pkg;

  localparam int ColorW = 8;
  localparam int HueW   = 13;
  localparam int FracW  = 17;
  localparam int GainW  = 12;
  localparam int ShiftW = 14;
  localparam int IndexW = 2;

  localparam logic [IndexW-1:0] CfgHueShift  = 2'd0;
  localparam logic [IndexW-1:0] CfgSatGain   = 2'd1;
  localparam logic [IndexW-1:0] CfgLightGain = 2'd2;

  localparam logic [HueW-1:0]  HueFull  = 13'd5760;
  localparam logic [FracW-1:0] Unit     = 17'h10000;
  localparam int               DivQuotW = 17;
  localparam logic [20:0]      Recip15  = 21'd1118482;

endpackage

// ===== rtl/hca_div_pipe.sv =====
// ----------------------------------------------------------------------------
// HSL color adjust pipelined divider
// Restoring division, one quotient bit per register stage, with a side word
// that travels alongside. The quotient must fit in QuotW bits.
// ----------------------------------------------------------------------------
module hca_div_pipe #(
  parameter int DivisorW = 8,
  parameter int QuotW    = 17,
  parameter int SideW    = 1
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [DivisorW+QuotW-1:0] dividend,
  input  logic [DivisorW-1:0]       divisor,
  input  logic [SideW-1:0]          side_in,
  output logic [QuotW-1:0]          quotient,
  output logic [SideW-1:0]          side_out
);

  logic [DivisorW-1:0] rem_q  [QuotW];
  logic [QuotW-1:0]    dq_q   [QuotW];
  logic [DivisorW-1:0] dvs_q  [QuotW];
  logic [SideW-1:0]    side_q [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    logic [DivisorW-1:0] rem_i;
    logic [DivisorW-1:0] dvs_i;
    logic [QuotW-1:0]    dq_i;
    logic [SideW-1:0]    side_i;
    logic [DivisorW:0]   trial;
    logic [DivisorW:0]   diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_i  = dividend[DivisorW+QuotW-1:QuotW];
      assign dq_i   = dividend[QuotW-1:0];
      assign dvs_i  = divisor;
      assign side_i = side_in;
    end else begin : g_rest
      assign rem_i  = rem_q[k-1];
      assign dq_i   = dq_q[k-1];
      assign dvs_i  = dvs_q[k-1];
      assign side_i = side_q[k-1];
    end

    assign trial = {rem_i, dq_i[QuotW-1]};
    assign ge    = trial >= {1'b0, dvs_i};
    assign diff  = trial - {1'b0, dvs_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[DivisorW-1:0] : trial[DivisorW-1:0];
        dq_q[k]   <= {dq_i[QuotW-2:0], ge};
        dvs_q[k]  <= dvs_i;
        side_q[k] <= side_i;
      end
    end
  end

  assign quotient = dq_q[QuotW-1];
  assign side_out = side_q[QuotW-1];

endmodule

// ===== rtl/hsl_color_adjust.sv =====
// ----------------------------------------------------------------------------
// HSL color adjust
// Converts an RGB color to HSL, shifts hue, scales saturation and lightness,
// and converts back to RGB.
//
//   Channel   Signals                                   Role
//   in        in_valid in_ready in_red in_green in_blue  input color word
//   out       out_valid out_ready out_red ...            adjusted color word
//   cfg       cfg_valid cfg_ready cfg_index cfg_data     register write
//
// One word is taken every cycle while out is not stalled; the pipeline is built from the 17
// stages of the saturation and hue dividers plus six arithmetic stages.
// Reset clears only the valid bits and loads the register defaults.
// A stall on out holds every stage; in_ready is low only while it lasts.
// ----------------------------------------------------------------------------
module hsl_color_adjust
  import hca_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ColorW-1:0] in_red,
  input  logic [ColorW-1:0] in_green,
  input  logic [ColorW-1:0] in_blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ColorW-1:0] out_red,
  output logic [ColorW-1:0] out_green,
  output logic [ColorW-1:0] out_blue,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IndexW-1:0] cfg_index,
  input  logic [ShiftW-1:0] cfg_data
);

  function automatic logic [FracW-1:0] scale_gain(input logic [FracW-1:0] v,
                                                  input logic [GainW-1:0] g);
    logic [FracW+GainW-1:0] p;
    p = v * g;
    scale_gain = (p[FracW+GainW-1:8] > {4'b0, Unit}) ? Unit : p[FracW-1+8:8];
  endfunction

  function automatic logic [ColorW-1:0] chan_out(input logic [FracW-1:0] comp,
                                                 input logic [FracW:0] tl,
                                                 input logic [FracW-1:0] c);
    logic [FracW+1:0] v;
    logic [FracW:0]   vc;
    logic [FracW+8:0] p;
    v  = {1'b0, comp, 1'b0} + {1'b0, tl} - {2'b0, c};
    vc = (v > {1'b0, Unit, 1'b0}) ? {Unit, 1'b0} : v[FracW:0];
    p  = vc * 8'd255;
    chan_out = p[FracW+7:FracW];
  endfunction

  logic signed [ShiftW-1:0] hue_shift;
  logic [GainW-1:0]         sat_gain;
  logic [GainW-1:0]         light_gain;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_shift  <= '0;
      sat_gain   <= 12'd256;
      light_gain <= 12'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgHueShift:  hue_shift  <= cfg_data;
        CfgSatGain:   sat_gain   <= cfg_data[GainW-1:0];
        CfgLightGain: light_gain <= cfg_data[GainW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Forward conversion front end.
  logic [ColorW-1:0] mx, mn, d, den;
  logic [ColorW:0]   sum, rsum;
  logic [16:0]       ly;
  logic [10:0]       n;
  logic [20:0]       hnum;
  logic [FracW-1:0]  l0;

  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    d    = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    rsum = 9'd510 - sum;
    den  = (sum < rsum) ? sum[ColorW-1:0] : rsum[ColorW-1:0];
    ly   = {1'b0, sum, 7'b0} + {9'b0, sum[8:1]} + 17'd1;
    l0   = {1'b0, sum, 7'b0} + {8'b0, ly[16:8]};
    if (mx == in_red) begin
      n = (in_green >= in_blue) ? {3'b0, in_green} - {3'b0, in_blue}
                                : {3'b0, in_green} + 11'd6 * {3'b0, d} - {3'b0, in_blue};
    end else if (mx == in_green) begin
      n = {3'b0, in_blue} + {2'b0, d, 1'b0} - {3'b0, in_red};
    end else begin
      n = {3'b0, in_red} + {1'b0, d, 2'b0} - {3'b0, in_green};
    end
    hnum = {n, 10'b0} - {4'b0, n, 6'b0};
  end

  logic             v1;
  logic [ColorW-1:0] d1, den1;
  logic [20:0]      hnum1;
  logic [FracW-1:0] l1;

  always_ff @(posedge clk) begin
    if (en) begin
      d1    <= d;
      den1  <= den;
      hnum1 <= hnum;
      l1    <= l0;
    end
  end

  logic [DivQuotW-1:0] sq, hq;
  logic [FracW-1:0]    l2;
  logic                zero2;

  hca_div_pipe #(.DivisorW(ColorW), .QuotW(DivQuotW), .SideW(FracW)) u_sat_div (
    .clk      (clk),
    .en       (en),
    .dividend ({1'b0, d1, 16'b0}),
    .divisor  (den1),
    .side_in  (l1),
    .quotient (sq),
    .side_out (l2)
  );

  hca_div_pipe #(.DivisorW(ColorW), .QuotW(DivQuotW), .SideW(1)) u_hue_div (
    .clk      (clk),
    .en       (en),
    .dividend ({4'b0, hnum1}),
    .divisor  (d1),
    .side_in  (d1 == '0),
    .quotient (hq),
    .side_out (zero2)
  );

  logic [DivQuotW-1:0] vdiv;

  // Adjustment.
  logic signed [15:0] h;
  logic [FracW-1:0]   s2;
  logic               va;
  logic [HueW-1:0]    hua;
  logic [FracW-1:0]   sa, la;

  always_comb begin
    s2 = zero2 ? '0 : sq;
    h  = signed'({3'b0, (zero2 ? 13'd0 : hq[HueW-1:0])}) + 16'(hue_shift);
    if (h < 0) h = h + 16'sd5760;
    if (h > 16'sd5760) h = h - 16'sd5760;
    if (h > 16'sd5760) h = h - 16'sd5760;
    if (h < 0) h = h + 16'sd5760;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hua <= h[HueW-1:0];
      sa  <= scale_gain(s2, sat_gain);
      la  <= scale_gain(l2, light_gain);
    end
  end

  // Chroma and hue weight.
  logic [FracW:0]   tl;
  logic [FracW:0]   ad;
  logic [FracW-1:0] cm;
  logic [2*FracW-1:0] cp;
  logic [HueW-1:0]  t;
  logic [9:0]       w;
  logic             vb;
  logic [FracW-1:0] cb;
  logic [9:0]       wb;
  logic [HueW-1:0]  hub;
  logic [FracW:0]   tlb;

  always_comb begin
    tl = {la, 1'b0};
    ad = (tl >= {1'b0, Unit}) ? tl - {1'b0, Unit} : {1'b0, Unit} - tl;
    cm = Unit - ad[FracW-1:0];
    cp = cm * sa;
    if (hua >= 13'd3840) t = hua - 13'd3840;
    else if (hua >= 13'd1920) t = hua - 13'd1920;
    else t = hua;
    w = (t >= 13'd960) ? 10'(13'd1920 - t) : t[9:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cb  <= cp[FracW+15:16];
      wb  <= w;
      hub <= hua;
      tlb <= tl;
    end
  end

  logic             vc;
  logic [25:0]      pc;
  logic [FracW-1:0] cc;
  logic [HueW-1:0]  huc;
  logic [FracW:0]   tlc;

  always_ff @(posedge clk) begin
    if (en) begin
      pc  <= 26'(cb * wb);
      cc  <= cb;
      huc <= hub;
      tlc <= tlb;
    end
  end

  logic [40:0]      xp;
  logic             vd;
  logic [FracW-1:0] xd, cd;
  logic [HueW-1:0]  hud;
  logic [FracW:0]   tld;

  assign xp = pc[25:6] * Recip15;

  always_ff @(posedge clk) begin
    if (en) begin
      xd  <= xp[40:24];
      cd  <= cc;
      hud <= huc;
      tld <= tlc;
    end
  end

  // Back conversion.
  logic [FracW-1:0] cr, cg, cbl;

  always_comb begin
    if (hud < 13'd960) begin
      cr = cd; cg = xd; cbl = '0;
    end else if (hud < 13'd1920) begin
      cr = xd; cg = cd; cbl = '0;
    end else if (hud < 13'd2880) begin
      cr = '0; cg = cd; cbl = xd;
    end else if (hud < 13'd3840) begin
      cr = '0; cg = xd; cbl = cd;
    end else if (hud < 13'd4800) begin
      cr = xd; cg = '0; cbl = cd;
    end else begin
      cr = cd; cg = '0; cbl = xd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_red   <= chan_out(cr, tld, cd);
      out_green <= chan_out(cg, tld, cd);
      out_blue  <= chan_out(cbl, tld, cd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      vdiv      <= '0;
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      vdiv      <= {vdiv[DivQuotW-2:0], v1};
      va        <= vdiv[DivQuotW-1];
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      out_valid <= vd;
    end
  end

endmodule
